[rtl/core/ecs_pkg.sv]
// Types and constants shared by the energy counter sampler.
package ecs_pkg;

  localparam int RAW_W     = 32;
  localparam int TOTAL_W   = 64;
  localparam int UNIT_W    = 30;
  localparam int ELAPSED_W = 40;
  localparam int DELTA_W   = 42;
  localparam int SCALED_W  = 52;
  localparam int MEM_W     = RAW_W + TOTAL_W;
  localparam int CNT_W     = 6;
  localparam int APB_AW    = 3;

  localparam logic [UNIT_W-1:0] UNIT_RESET = UNIT_W'(62500);
  localparam logic [UNIT_W-1:0] NS_PER_S   = UNIT_W'(1000000000);
  localparam logic [DELTA_W-1:0] DELTA_MAX = '1;

  localparam logic [2:0] DRAM_DOMAIN = 3'd3;

  localparam logic REQ_PRIME  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Register select bit of paddr: 0 main unit, 1 dram unit
  localparam logic REG_MAIN_UNIT = 1'b0;
  localparam logic REG_DRAM_UNIT = 1'b1;

  // Multiplier steps: 2 bits of a 30-bit operand per cycle
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(UNIT_W / 2 - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(TOTAL_W - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_TRIPLE_E,
    ST_MUL_E,
    ST_TRIPLE_P,
    ST_MUL_P,
    ST_DIVIDE,
    ST_DONE
  } state_t;

endpackage

[rtl/core/energy_counter_sampler.sv]
// Energy counter sampler: per-slot counter delta, cumulative energy and average power.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_stall   | req_type, package/domain index, raw counter,
//           |           |                     | elapsed_ns, read_ok
//   out     | output    | out_valid/out_stall | delta_uj, total_uj, avg_power, updated
//   cfg     | input     | APB psel/penable    | main_unit_scaled at 0x0, dram_unit_scaled at 0x4
//
// A sample passes in order through the slot read, two shift-add multiplies retiring
// 2 bits per cycle (each after a step that forms the 3x multiple), a restoring divider
// retiring one quotient bit per cycle, the output load and idle; in_stall holds off new
// samples until idle. A prime, a failed read or an out-of-range slot skips to output load.
// After reset the slot memory is cleared one slot per cycle, all PACKAGES*DOMAINS slots,
// with in_stall high. A finished result waits while the output register is full and stalled.
module energy_counter_sampler #(
  parameter int PACKAGES = 4,
  parameter int DOMAINS  = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [1:0]                    in_package_index,
  input  logic [2:0]                    in_domain_index,
  input  logic [ecs_pkg::RAW_W-1:0]     in_raw_counter,
  input  logic [ecs_pkg::ELAPSED_W-1:0] in_elapsed_ns,
  input  logic                          in_read_ok,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ecs_pkg::DELTA_W-1:0]   out_delta_uj,
  output logic [ecs_pkg::TOTAL_W-1:0]   out_total_uj,
  output logic [ecs_pkg::TOTAL_W-1:0]   out_avg_power,
  output logic                          out_updated,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ecs_pkg::APB_AW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int SLOTS  = PACKAGES * DOMAINS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  ecs_pkg::state_t state_r, state_nxt;

  // Configuration
  logic [ecs_pkg::UNIT_W-1:0] main_unit_r, dram_unit_r;

  // Slot memory: {previous raw counter, energy total}
  logic [ecs_pkg::MEM_W-1:0] mem [SLOTS];
  logic [ecs_pkg::MEM_W-1:0] rd_data_r;
  logic                      mem_we;
  logic [SLOT_W-1:0]         mem_wa;
  logic [ecs_pkg::MEM_W-1:0] mem_wd;
  logic [SLOT_W-1:0]         clr_cnt_r, clr_cnt_nxt;

  // Latched transaction
  logic                          sample_r, ok_r, in_range_r, dram_r;
  logic [SLOT_W-1:0]             slot_r;
  logic [ecs_pkg::RAW_W-1:0]     raw_r;
  logic [ecs_pkg::ELAPSED_W-1:0] div_r;

  // Arithmetic
  logic [ecs_pkg::TOTAL_W-1:0]   mcand_r, mcand_nxt;
  logic [ecs_pkg::TOTAL_W-1:0]   m3_r, m3_nxt;
  logic [ecs_pkg::TOTAL_W-1:0]   acc_r, acc_nxt;
  logic [ecs_pkg::UNIT_W-1:0]    mplier_r, mplier_nxt;
  logic [ecs_pkg::ELAPSED_W-1:0] rem_r, rem_nxt;
  logic [ecs_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ecs_pkg::SCALED_W-1:0]  delta_r, delta_nxt;
  logic [ecs_pkg::TOTAL_W-1:0]   total_r, total_nxt;
  logic                          upd_r, upd_nxt;

  logic [ecs_pkg::TOTAL_W-1:0]   addend, acc_sum;
  logic [ecs_pkg::ELAPSED_W:0]   rem_sh, rem_diff;
  logic                          rem_ge;

  logic                          accept, in_range, out_load, cfg_wr;
  logic [SLOT_W-1:0]             in_slot;
  logic [ecs_pkg::RAW_W-1:0]     rd_raw;
  logic [ecs_pkg::TOTAL_W-1:0]   rd_total;
  logic [ecs_pkg::RAW_W-1:0]     ctr_delta;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ecs_pkg::ST_IDLE);
  assign out_load = (state_r == ecs_pkg::ST_DONE) && (!out_valid || !out_stall);

  assign in_range = (32'(in_package_index) < PACKAGES) && (32'(in_domain_index) < DOMAINS);
  assign in_slot  = SLOT_W'(32'(in_package_index) * DOMAINS + 32'(in_domain_index));

  assign rd_raw    = rd_data_r[ecs_pkg::MEM_W-1:ecs_pkg::TOTAL_W];
  assign rd_total  = rd_data_r[ecs_pkg::TOTAL_W-1:0];
  assign ctr_delta = raw_r - rd_raw;

  // Shift-add step: pick 0, 1x, 2x or 3x of the multiplicand by the low digit
  always_comb begin
    case (mplier_r[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = mcand_r;
      2'd2:    addend = {mcand_r[ecs_pkg::TOTAL_W-2:0], 1'b0};
      default: addend = m3_r;
    endcase
  end
  assign acc_sum = acc_r + addend;

  // Restoring divide step: quotient bits shift into acc_r from the right
  assign rem_sh   = {rem_r, acc_r[ecs_pkg::TOTAL_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, div_r});
  assign rem_diff = rem_sh - {1'b0, div_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ecs_pkg::ST_CLEAR: begin
        if (clr_cnt_r == SLOT_W'(SLOTS - 1)) state_nxt = ecs_pkg::ST_IDLE;
      end
      ecs_pkg::ST_IDLE: begin
        if (accept) state_nxt = ecs_pkg::ST_READ;
      end
      ecs_pkg::ST_READ: begin
        if (in_range_r && ok_r && (sample_r == ecs_pkg::REQ_SAMPLE)) begin
          state_nxt = ecs_pkg::ST_TRIPLE_E;
        end else begin
          state_nxt = ecs_pkg::ST_DONE;
        end
      end
      ecs_pkg::ST_TRIPLE_E: state_nxt = ecs_pkg::ST_MUL_E;
      ecs_pkg::ST_MUL_E: begin
        if (cnt_r == '0) state_nxt = ecs_pkg::ST_TRIPLE_P;
      end
      ecs_pkg::ST_TRIPLE_P: state_nxt = ecs_pkg::ST_MUL_P;
      ecs_pkg::ST_MUL_P: begin
        if (cnt_r == '0) state_nxt = ecs_pkg::ST_DIVIDE;
      end
      ecs_pkg::ST_DIVIDE: begin
        if (cnt_r == '0) state_nxt = ecs_pkg::ST_DONE;
      end
      ecs_pkg::ST_DONE: begin
        if (out_load) state_nxt = ecs_pkg::ST_IDLE;
      end
      default: state_nxt = ecs_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory write controls
  always_comb begin
    mcand_nxt   = mcand_r;
    m3_nxt      = m3_r;
    acc_nxt     = acc_r;
    mplier_nxt  = mplier_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    delta_nxt   = delta_r;
    total_nxt   = total_r;
    upd_nxt     = upd_r;
    clr_cnt_nxt = clr_cnt_r;
    mem_we      = 1'b0;
    mem_wa      = slot_r;
    mem_wd      = {raw_r, rd_total};
    unique case (state_r)
      ecs_pkg::ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_cnt_r;
        mem_wd      = '0;
        clr_cnt_nxt = clr_cnt_r + SLOT_W'(1);
      end
      ecs_pkg::ST_READ: begin
        // Default result for prime, failed read or missing slot
        delta_nxt  = '0;
        acc_nxt    = '0;
        upd_nxt    = 1'b0;
        total_nxt  = in_range_r ? rd_total : '0;
        mcand_nxt  = ecs_pkg::TOTAL_W'(ctr_delta);
        mplier_nxt = dram_r ? dram_unit_r : main_unit_r;
        cnt_nxt    = ecs_pkg::MUL_LAST;
        // Prime: store the counter, keep the total
        mem_we     = in_range_r && ok_r && (sample_r == ecs_pkg::REQ_PRIME);
      end
      ecs_pkg::ST_TRIPLE_E, ecs_pkg::ST_TRIPLE_P: begin
        m3_nxt = mcand_r + {mcand_r[ecs_pkg::TOTAL_W-2:0], 1'b0};
        if (state_r == ecs_pkg::ST_TRIPLE_P) begin
          total_nxt = rd_total + ecs_pkg::TOTAL_W'(delta_r);
          upd_nxt   = 1'b1;
          mem_we    = 1'b1;
          mem_wd    = {raw_r, rd_total + ecs_pkg::TOTAL_W'(delta_r)};
        end
      end
      ecs_pkg::ST_MUL_E, ecs_pkg::ST_MUL_P: begin
        acc_nxt    = acc_sum;
        mcand_nxt  = {mcand_r[ecs_pkg::TOTAL_W-3:0], 2'b00};
        m3_nxt     = {m3_r[ecs_pkg::TOTAL_W-3:0], 2'b00};
        mplier_nxt = {2'b00, mplier_r[ecs_pkg::UNIT_W-1:2]};
        cnt_nxt    = cnt_r - ecs_pkg::CNT_W'(1);
        if (cnt_r == '0) begin
          if (state_r == ecs_pkg::ST_MUL_E) begin
            // Drop the 10 fraction bits, then scale by 1e9 ns per second
            delta_nxt  = acc_sum[ecs_pkg::SCALED_W+9:10];
            mcand_nxt  = ecs_pkg::TOTAL_W'(acc_sum[ecs_pkg::SCALED_W+9:10]);
            mplier_nxt = ecs_pkg::NS_PER_S;
            acc_nxt    = '0;
            cnt_nxt    = ecs_pkg::MUL_LAST;
          end else begin
            rem_nxt = '0;
            cnt_nxt = ecs_pkg::DIV_LAST;
          end
        end
      end
      ecs_pkg::ST_DIVIDE: begin
        rem_nxt = rem_ge ? rem_diff[ecs_pkg::ELAPSED_W-1:0] : rem_sh[ecs_pkg::ELAPSED_W-1:0];
        acc_nxt = {acc_r[ecs_pkg::TOTAL_W-2:0], rem_ge};
        cnt_nxt = cnt_r - ecs_pkg::CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ecs_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    m3_r     <= m3_nxt;
    acc_r    <= acc_nxt;
    mplier_r <= mplier_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    delta_r  <= delta_nxt;
    total_r  <= total_nxt;
    upd_r    <= upd_nxt;
    if (accept) begin
      sample_r   <= in_req_type;
      ok_r       <= in_read_ok;
      in_range_r <= in_range;
      dram_r     <= (in_domain_index == ecs_pkg::DRAM_DOMAIN);
      slot_r     <= in_slot;
      raw_r      <= in_raw_counter;
      // Zero elapsed time counts as one nanosecond
      div_r      <= (in_elapsed_ns == '0) ? ecs_pkg::ELAPSED_W'(1) : in_elapsed_ns;
    end
    if (out_load) begin
      out_delta_uj  <= (|delta_r[ecs_pkg::SCALED_W-1:ecs_pkg::DELTA_W]) ?
                       ecs_pkg::DELTA_MAX : delta_r[ecs_pkg::DELTA_W-1:0];
      out_total_uj  <= total_r;
      out_avg_power <= acc_r;
      out_updated   <= upd_r;
    end
  end

  // Slot memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (accept && in_range) rd_data_r <= mem[in_slot];
  end

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_unit_r <= ecs_pkg::UNIT_RESET;
      dram_unit_r <= ecs_pkg::UNIT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        ecs_pkg::REG_MAIN_UNIT: main_unit_r <= pwdata[ecs_pkg::UNIT_W-1:0];
        ecs_pkg::REG_DRAM_UNIT: dram_unit_r <= pwdata[ecs_pkg::UNIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ecs_pkg::REG_MAIN_UNIT: prdata = 32'(main_unit_r);
      ecs_pkg::REG_DRAM_UNIT: prdata = 32'(dram_unit_r);
      default:                prdata = '0;
    endcase
  end

endmodule

[sim/energy_counter_sampler_tb.sv]
// Self-checking testbench for the energy counter sampler: predicted slot energy and power.
`timescale 1ns / 1ps

module energy_counter_sampler_tb;

  localparam int PACKAGES    = 4;
  localparam int DOMAINS     = 5;
  localparam int SLOTS       = PACKAGES * DOMAINS;
  localparam int HALF_PERIOD = 10;
  localparam int RAND_PHASES = 7;
  localparam int PER_PHASE   = 154;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 120;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam logic [31:0] UNIT_MAX = 32'h3FFF_FFFF;
  localparam logic [31:0] UNIT_DEFAULT = 32'd62500;
  localparam logic [ecs_pkg::DELTA_W-1:0] DELTA_CAP = '1;
  localparam logic [63:0] NS_PER_SEC = 64'd1_000_000_000;

  typedef struct packed {
    logic                          req_type;
    logic [1:0]                    pkg;
    logic [2:0]                    dom;
    logic [ecs_pkg::RAW_W-1:0]     raw;
    logic [ecs_pkg::ELAPSED_W-1:0] elapsed;
    logic                          ok;
  } reading_t;

  typedef struct packed {
    logic [ecs_pkg::DELTA_W-1:0] delta;
    logic [ecs_pkg::TOTAL_W-1:0] total;
    logic [ecs_pkg::TOTAL_W-1:0] power;
    logic                        updated;
  } report_t;

  // Tracks slot state and unit registers; predicts one report per accepted reading.
  class energy_ledger;
    logic [ecs_pkg::UNIT_W-1:0]  main_unit;
    logic [ecs_pkg::UNIT_W-1:0]  dram_unit;
    logic [ecs_pkg::RAW_W-1:0]   last_raw[SLOTS];
    logic [ecs_pkg::TOTAL_W-1:0] slot_total[SLOTS];
    report_t reports_due[$];
    int mismatches, checked, n_sample, n_prime, n_failed, n_unused, n_saturated, n_settings;

    function new();
      main_unit = ecs_pkg::UNIT_RESET;
      dram_unit = ecs_pkg::UNIT_RESET;
      foreach (last_raw[i]) begin
        last_raw[i] = '0;
        slot_total[i] = '0;
      end
    endfunction

    function void set_unit(logic sel, logic [31:0] data);
      if (sel == ecs_pkg::REG_DRAM_UNIT) dram_unit = data[ecs_pkg::UNIT_W-1:0];
      else main_unit = data[ecs_pkg::UNIT_W-1:0];
    endfunction

    function void audit_unit(logic sel, logic [31:0] got);
      logic [31:0] want;
      want = 32'((sel == ecs_pkg::REG_DRAM_UNIT) ? dram_unit : main_unit);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unit register %0d read: expected %0d, got %0d", sel, want, got);
      end
    endfunction

    function void account_reading(reading_t r);
      logic [31:0] count_step;
      logic [ecs_pkg::UNIT_W-1:0] unit;
      logic [63:0] scaled, divisor;
      int slot;
      report_t e;
      e = '0;
      if (r.pkg < PACKAGES && r.dom < DOMAINS) begin
        slot = int'(r.pkg) * DOMAINS + int'(r.dom);
        if (!r.ok) n_failed++;
        else if (r.req_type == ecs_pkg::REQ_SAMPLE) begin
          count_step = r.raw - last_raw[slot];
          unit = (r.dom == ecs_pkg::DRAM_DOMAIN) ? dram_unit : main_unit;
          scaled = (64'(count_step) * 64'(unit)) >> 10;
          slot_total[slot] += scaled;
          divisor = (r.elapsed == '0) ? 64'd1 : 64'(r.elapsed);
          e.power = (scaled * NS_PER_SEC) / divisor;
          if (scaled > 64'(DELTA_CAP)) begin
            e.delta = DELTA_CAP;
            n_saturated++;
          end else begin
            e.delta = scaled[ecs_pkg::DELTA_W-1:0];
          end
          e.updated = 1'b1;
          n_sample++;
        end else begin
          n_prime++;
        end
        if (r.ok) last_raw[slot] = r.raw;
        e.total = slot_total[slot];
      end else begin
        n_unused++;
      end
      reports_due.push_back(e);
    endfunction

    function void audit_report(report_t got);
      report_t e;
      checked++;
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report with nothing pending: delta %0d total %0d power %0d updated %0d",
                   got.delta, got.total, got.power, got.updated);
        return;
      end
      e = reports_due.pop_front();
      if (got.delta !== e.delta || got.total !== e.total || got.power !== e.power ||
          got.updated !== e.updated) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("report %0d: expected delta %0d total %0d power %0d updated %0d",
                   checked, e.delta, e.total, e.power, e.updated);
          $display("report %0d:   actual delta %0d total %0d power %0d updated %0d",
                   checked, got.delta, got.total, got.power, got.updated);
        end
      end
    endfunction

    function int pending();
      return reports_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall, in_req_type, in_read_ok;
  logic [1:0] in_package_index;
  logic [2:0] in_domain_index;
  logic [ecs_pkg::RAW_W-1:0] in_raw_counter;
  logic [ecs_pkg::ELAPSED_W-1:0] in_elapsed_ns;
  logic out_valid, out_stall, out_updated;
  logic [ecs_pkg::DELTA_W-1:0] out_delta_uj;
  logic [ecs_pkg::TOTAL_W-1:0] out_total_uj, out_avg_power;
  logic psel, penable, pwrite, pready;
  logic [ecs_pkg::APB_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  energy_ledger ledger;
  logic [ecs_pkg::RAW_W-1:0] shaped_raw[SLOTS];
  bit hold_req = 1'b0;
  int cycle_count = 0;

  energy_counter_sampler #(.PACKAGES(PACKAGES), .DOMAINS(DOMAINS)) dut (.*);

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports pending", cycle_count, ledger.pending());
      $display("energy_counter_sampler: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      ledger.audit_report('{out_delta_uj, out_total_uj, out_avg_power, out_updated});
  end

  // Receiver: random stall runs, plus one long hold-off on request.
  initial begin
    int roll, len;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          out_stall = 1'b0;
          len = $urandom_range(1, 40);
        end else if (roll < 90) begin
          out_stall = 1'b1;
          len = $urandom_range(1, 4);
        end else begin
          out_stall = 1'b1;
          len = $urandom_range(20, 150);
        end
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  function automatic reading_t mk(logic t, logic [1:0] p, logic [2:0] d, logic [31:0] raw,
                                  logic [39:0] el, logic ok);
    reading_t r;
    r.req_type = t;
    r.pkg = p;
    r.dom = d;
    r.raw = raw;
    r.elapsed = el;
    r.ok = ok;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (hold_req || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 5);
    if (roll < 98) return $urandom_range(6, 40);
    return $urandom_range(100, 300);
  endfunction

  // Mostly well-formed samples that advance the slot counter; some noise.
  function automatic reading_t random_reading();
    reading_t r;
    logic [63:0] wide;
    int roll, slot;
    wide = {$urandom(), $urandom()};
    r.pkg = 2'($urandom_range(0, 3));
    r.dom = ($urandom_range(0, 99) < 5) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    r.ok = $urandom_range(0, 99) < 90;
    r.req_type = ($urandom_range(0, 99) < 20) ? ecs_pkg::REQ_PRIME : ecs_pkg::REQ_SAMPLE;
    slot = (r.dom < DOMAINS) ? int'(r.pkg) * DOMAINS + int'(r.dom) : 0;
    case ($urandom_range(0, 3))
      0: r.raw = $urandom();
      1: r.raw = shaped_raw[slot] + 32'($urandom_range(0, 1000));
      2: r.raw = shaped_raw[slot] + 32'($urandom_range(0, 1 << 20));
      default: r.raw = shaped_raw[slot] - 32'($urandom_range(1, 16));
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 5) r.elapsed = '0;
    else if (roll < 30) r.elapsed = 40'($urandom_range(1, 1000));
    else if (roll < 65) r.elapsed = 40'($urandom_range(1_000_000, 100_000_000));
    else if (roll < 97) r.elapsed = wide[39:0];
    else r.elapsed = '1;
    return r;
  endfunction

  task automatic send_reading(reading_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_raw_counter = $urandom();
      in_domain_index = 3'($urandom());
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_req_type = r.req_type;
    in_package_index = r.pkg;
    in_domain_index = r.dom;
    in_raw_counter = r.raw;
    in_elapsed_ns = r.elapsed;
    in_read_ok = r.ok;
    do @(posedge clk); while (in_stall);
    ledger.account_reading(r);
    if (r.dom < DOMAINS && r.ok) shaped_raw[int'(r.pkg) * DOMAINS + int'(r.dom)] = r.raw;
  endtask

  task automatic apb_access(logic wr, logic sel, logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {sel, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) ledger.set_unit(sel, data);
    else ledger.audit_unit(sel, prdata);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic program_units(logic [31:0] main_data, logic [31:0] dram_data);
    // Drop valid so the last transaction is not taken again while the block drains
    @(negedge clk);
    in_valid = 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    apb_access(1'b1, ecs_pkg::REG_MAIN_UNIT, main_data);
    apb_access(1'b1, ecs_pkg::REG_DRAM_UNIT, dram_data);
    apb_access(1'b0, ecs_pkg::REG_MAIN_UNIT, '0);
    apb_access(1'b0, ecs_pkg::REG_DRAM_UNIT, '0);
    ledger.n_settings++;
  endtask

  initial begin
    logic [31:0] main_pick[RAND_PHASES];
    logic [31:0] dram_pick[RAND_PHASES];
    int issued;
    reading_t r;
    ledger = new();
    foreach (shaped_raw[i]) shaped_raw[i] = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = ecs_pkg::REQ_PRIME;
    in_package_index = '0;
    in_domain_index = '0;
    in_raw_counter = '0;
    in_elapsed_ns = '0;
    in_read_ok = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    do @(posedge clk); while (in_stall);

    // Reset units: wrap, zero and maximum elapsed, failed reads, unused slots.
    apb_access(1'b0, ecs_pkg::REG_MAIN_UNIT, '0);
    apb_access(1'b0, ecs_pkg::REG_DRAM_UNIT, '0);
    ledger.n_settings++;
    send_reading(mk(ecs_pkg::REQ_SAMPLE, 2'd0, 3'd0, 32'h64, 40'd1000, 1'b1));
    send_reading(mk(ecs_pkg::REQ_PRIME, 2'd0, 3'd0, 32'hFFFF_FFF0, '0, 1'b1));
    send_reading(mk(ecs_pkg::REQ_SAMPLE, 2'd0, 3'd0, 32'h10, '0, 1'b1));
    send_reading(mk(ecs_pkg::REQ_SAMPLE, 2'd0, 3'd0, 32'h20, 40'd5, 1'b0));
    send_reading(mk(ecs_pkg::REQ_PRIME, 2'd0, 3'd0, 32'h0, 40'd5, 1'b0));
    send_reading(mk(ecs_pkg::REQ_SAMPLE, 2'd0, 3'd0, 32'h30, '1, 1'b1));
    send_reading(mk(ecs_pkg::REQ_SAMPLE, 2'd0, 3'd0, 32'h30, 40'd7, 1'b1));
    send_reading(mk(ecs_pkg::REQ_PRIME, 2'd1, ecs_pkg::DRAM_DOMAIN, 32'h0, '0, 1'b1));
    send_reading(mk(ecs_pkg::REQ_SAMPLE, 2'd1, ecs_pkg::DRAM_DOMAIN, 32'hFFFF_FFFF, 40'd1, 1'b1));
    send_reading(mk(ecs_pkg::REQ_SAMPLE, 2'd3, 3'd4, 32'hFFFF_FFFF, '1, 1'b1));
    send_reading(mk(ecs_pkg::REQ_SAMPLE, 2'd2, 3'd5, 32'h1234_5678, 40'd9, 1'b1));
    send_reading(mk(ecs_pkg::REQ_SAMPLE, 2'd2, 3'd6, 32'hDEAD_BEEF, '0, 1'b1));
    send_reading(mk(ecs_pkg::REQ_PRIME, 2'd3, 3'd7, 32'hFFFF_FFFF, '1, 1'b1));
    send_reading(mk(ecs_pkg::REQ_SAMPLE, 2'd1, 3'd1, 32'h0001_0000, 40'd3_000_000, 1'b1));
    send_reading(mk(ecs_pkg::REQ_SAMPLE, 2'd1, 3'd2, 32'h8000_0000, 40'd55, 1'b1));

    // Largest unit: saturated delta and wrapped power product; DRAM unit zero.
    program_units(UNIT_MAX, '0);
    send_reading(mk(ecs_pkg::REQ_PRIME, 2'd2, 3'd0, 32'h0, '0, 1'b1));
    send_reading(mk(ecs_pkg::REQ_SAMPLE, 2'd2, 3'd0, 32'hFFFF_FFFF, '0, 1'b1));
    send_reading(mk(ecs_pkg::REQ_SAMPLE, 2'd2, ecs_pkg::DRAM_DOMAIN, 32'h0012_3456, 40'd1, 1'b1));
    send_reading(mk(ecs_pkg::REQ_SAMPLE, 2'd2, 3'd1, 32'h8000_0000, 40'd1, 1'b1));

    program_units('0, UNIT_MAX);
    send_reading(mk(ecs_pkg::REQ_SAMPLE, 2'd2, 3'd0, 32'h7, 40'd100, 1'b1));
    send_reading(mk(ecs_pkg::REQ_PRIME, 2'd2, ecs_pkg::DRAM_DOMAIN, 32'h0, '0, 1'b1));
    send_reading(mk(ecs_pkg::REQ_SAMPLE, 2'd2, ecs_pkg::DRAM_DOMAIN, 32'hFFFF_FFFF, '0, 1'b1));
    send_reading(mk(ecs_pkg::REQ_SAMPLE, 2'd0, ecs_pkg::DRAM_DOMAIN, 32'h4000_0000, '1, 1'b1));

    main_pick = '{$urandom(), UNIT_DEFAULT, 32'd1024000000, UNIT_MAX, $urandom(), 32'd1, $urandom()};
    dram_pick = '{$urandom(), 32'd1024000000, UNIT_DEFAULT, UNIT_MAX, $urandom(), 32'd1, '0};
    for (int p = 0; p < RAND_PHASES; p++) begin
      program_units(main_pick[p], dram_pick[p]);
      issued = 0;
      while (issued < PER_PHASE) begin
        // Hold the output off mid-run so the block backs up into its input.
        if (p == 3 && issued == 40) hold_req = 1'b1;
        r = random_reading();
        send_reading(r);
        if (r.dom < DOMAINS) issued++;
      end
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (ledger.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d transactions: %0d samples (%0d saturated), %0d primes, %0d failed reads",
             ledger.checked, ledger.n_sample, ledger.n_saturated, ledger.n_prime, ledger.n_failed);
    $display("%0d unused-slot readings over %0d unit settings, one %0d-cycle output hold-off",
             ledger.n_unused, ledger.n_settings, HOLD_CYCLES);
    if (ledger.mismatches == 0) begin
      $display("energy_counter_sampler: match");
    end else begin
      $display("%0d mismatches", ledger.mismatches);
      $display("energy_counter_sampler: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/ecs_pkg.sv
rtl/core/energy_counter_sampler.sv
sim/energy_counter_sampler_tb.sv
